>>> rtl/wsfe_pkg.sv
// Shared types, constants and header byte helpers for the socket frame encoder.
package wsfe_pkg;

    localparam logic [7:0]  OPCODE_TEXT = 8'h81;
    localparam logic [7:0]  MASK_BIT    = 8'h80;
    localparam logic [7:0]  LEN16_MARK  = 8'd126;
    localparam logic [7:0]  LEN64_MARK  = 8'd127;
    localparam logic [62:0] SHORT_MAX   = 63'd125;
    localparam logic [62:0] MID_MAX     = 63'd65535;
    localparam logic [31:0] KEY_RESET   = 32'h12345678;
    localparam int          IDX_W       = 4;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_MID,
        FORM_LONG
    } len_form_t;

    typedef enum logic {
        ST_IDLE,
        ST_HDR
    } back_state_t;

    typedef struct packed {
        logic        is_start;
        len_form_t   form;
        logic [62:0] frame_length;
        logic [7:0]  data;
    } wsfe_entry_t;

    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

    // Index of the final header byte for each length form
    function automatic logic [IDX_W-1:0] last_idx(input len_form_t form);
        logic [IDX_W-1:0] n;
        case (form)
            FORM_SHORT: n = IDX_W'(5);
            FORM_MID:   n = IDX_W'(7);
            default:    n = IDX_W'(13);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] hdr_byte(
        input len_form_t        form,
        input logic [62:0]      len,
        input logic [IDX_W-1:0] idx,
        input logic [31:0]      key
    );
        logic [63:0]      len64;
        logic [IDX_W-1:0] rel;
        logic [2:0]       sel;
        logic [7:0]       b;
        len64 = {1'b0, len};
        rel   = idx - IDX_W'(2);
        sel   = 3'(IDX_W'(9) - idx);
        b     = OPCODE_TEXT;
        case (form)
            FORM_SHORT: begin
                case (idx) inside
                    IDX_W'(0):              b = OPCODE_TEXT;
                    IDX_W'(1):              b = MASK_BIT | {1'b0, len[6:0]};
                    default:                b = key_byte(key, rel[1:0]);
                endcase
            end
            FORM_MID: begin
                case (idx) inside
                    IDX_W'(0):              b = OPCODE_TEXT;
                    IDX_W'(1):              b = MASK_BIT | LEN16_MARK;
                    IDX_W'(2):              b = len[15:8];
                    IDX_W'(3):              b = len[7:0];
                    default:                b = key_byte(key, idx[1:0]);
                endcase
            end
            default: begin
                case (idx) inside
                    IDX_W'(0):              b = OPCODE_TEXT;
                    IDX_W'(1):              b = MASK_BIT | LEN64_MARK;
                    [IDX_W'(2):IDX_W'(9)]:  b = 8'(len64 >> {sel, 3'b000});
                    default:                b = key_byte(key, rel[1:0]);
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

>>> rtl/wsfe_front.sv
// Front end: accepts input beats, classifies the length form and masks payload bytes.
module wsfe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [62:0]          frame_length,
    input  logic [7:0]           payload_byte,
    input  logic [31:0]          mask_key,
    input  logic                 queue_full,
    output logic                 push,
    output wsfe_pkg::wsfe_entry_t push_entry
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_entry.is_start     = !mode;
        push_entry.frame_length = frame_length;
        push_entry.data         = payload_byte ^ wsfe_pkg::key_byte(mask_key, phase_reg);
        if (frame_length <= wsfe_pkg::SHORT_MAX)
        begin
            push_entry.form = wsfe_pkg::FORM_SHORT;
        end
        else if (frame_length <= wsfe_pkg::MID_MAX)
        begin
            push_entry.form = wsfe_pkg::FORM_MID;
        end
        else
        begin
            push_entry.form = wsfe_pkg::FORM_LONG;
        end
    end

    // Start clears the byte position; each payload byte advances it
    always_comb
    begin
        phase_next = phase_reg;
        if (push)
        begin
            phase_next = mode ? phase_reg + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> rtl/wsfe_queue.sv
// Small queue of classified items between the front end and the byte sequencer.
module wsfe_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wsfe_pkg::wsfe_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output wsfe_pkg::wsfe_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsfe_pkg::wsfe_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/wsfe_back.sv
// Back end: expands queued items into frame bytes and holds the output register.
module wsfe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  wsfe_pkg::wsfe_entry_t head_entry,
    output logic                  pop,
    input  logic [31:0]           mask_key,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  is_header,
    output logic                  last
);

    wsfe_pkg::back_state_t state_reg, state_next;
    wsfe_pkg::wsfe_entry_t cur_reg;
    logic [wsfe_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [wsfe_pkg::IDX_W-1:0] hdr_end;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       is_header_reg;
    logic       last_reg;

    logic       advance;
    logic       emit;
    logic       load_cur;
    logic [7:0] emit_byte;
    logic       emit_hdr;
    logic       emit_last;

    assign advance = !out_valid_reg || out_ready;
    assign hdr_end = wsfe_pkg::last_idx(cur_reg.form);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsfe_pkg::ST_IDLE:
            begin
                if (advance && head_valid && head_entry.is_start)
                begin
                    state_next = wsfe_pkg::ST_HDR;
                end
            end
            wsfe_pkg::ST_HDR:
            begin
                if (advance && idx_reg == hdr_end)
                begin
                    state_next = wsfe_pkg::ST_IDLE;
                end
            end
            default: state_next = wsfe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        emit      = 1'b0;
        load_cur  = 1'b0;
        emit_byte = head_entry.data;
        emit_hdr  = 1'b0;
        emit_last = 1'b1;
        case (state_reg)
            wsfe_pkg::ST_IDLE:
            begin
                if (advance && head_valid)
                begin
                    pop  = 1'b1;
                    emit = 1'b1;
                    if (head_entry.is_start)
                    begin
                        load_cur  = 1'b1;
                        emit_byte = wsfe_pkg::OPCODE_TEXT;
                        emit_hdr  = 1'b1;
                        emit_last = 1'b0;
                    end
                end
            end
            wsfe_pkg::ST_HDR:
            begin
                emit      = advance;
                emit_byte = wsfe_pkg::hdr_byte(cur_reg.form, cur_reg.frame_length,
                                               idx_reg, mask_key);
                emit_hdr  = 1'b1;
                emit_last = (idx_reg == hdr_end);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load_cur)
        begin
            idx_next = wsfe_pkg::IDX_W'(1);
        end
        else if (emit)
        begin
            idx_next = idx_reg + wsfe_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsfe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cur)
        begin
            cur_reg <= head_entry;
        end
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            is_header_reg <= emit_hdr;
            last_reg      <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_header = is_header_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_hdr_keeps_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wsfe_pkg::ST_HDR |-> out_valid_reg)
        else $error("header run without a valid output beat");

    a_hdr_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsfe_pkg::ST_HDR && advance && idx_reg == hdr_end)
        |=> state_reg == wsfe_pkg::ST_IDLE)
        else $error("header run did not end after its last byte");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wsfe_pkg::ST_HDR |-> (idx_reg <= hdr_end && idx_reg != '0))
        else $error("header byte index out of range");

    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last && state_reg == wsfe_pkg::ST_HDR) |=> state_reg == wsfe_pkg::ST_IDLE)
        else $error("last header byte left the sequencer busy");
`endif

endmodule

>>> rtl/websocket_frame_encoder.sv
// Top level: masked client text frame encoder with a front end, queue and byte sequencer.
// An accepted beat is registered in the queue and then in the byte sequencer's output register.
// Throughput: one payload beat per cycle while out_ready holds and no header run is busy; a start
// beat expands into 6, 8 or 14 header bytes, sent one per cycle while out_ready holds.
// Reset (rst_n, asynchronous, active low) empties the queue and output register, clears the
// byte position and loads the mask key with 0x12345678.
module websocket_frame_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [62:0] frame_length,
    input  logic [7:0]  payload_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_header,
    output logic        last,
    // mask key register write
    input  logic        mask_key_we,
    input  logic [31:0] mask_key_wdata
);

    logic [31:0] mask_key_reg;
    logic [31:0] mask_key_next;

    logic                  push;
    logic                  queue_full;
    wsfe_pkg::wsfe_entry_t push_entry;
    logic                  pop;
    logic                  head_valid;
    wsfe_pkg::wsfe_entry_t head_entry;

    // Key writes must wait for a drained encoder so both ends see one key per frame; not enforced here
    always_comb
    begin
        mask_key_next = mask_key_we ? mask_key_wdata : mask_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_key_reg <= wsfe_pkg::KEY_RESET;
        end
        else
        begin
            mask_key_reg <= mask_key_next;
        end
    end

    // Front end: classify the length form and mask payload bytes at the accepted beat
    wsfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .frame_length (frame_length),
        .payload_byte (payload_byte),
        .mask_key     (mask_key_reg),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Queue lets the front keep accepting while a header run drains
    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back end: expand each item into wire bytes, one per cycle while out_ready holds, into the output register
    wsfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .mask_key   (mask_key_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_header  (is_header),
        .last       (last)
    );

endmodule
